### sv/ont_pkg.sv
// ----------------------------------------------------------------------------
// Ordered name table package
// Shared types, codes and default sizes for the ordered name table unit.
// ----------------------------------------------------------------------------
package ont_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int NAME_BYTES_DEF = 9;
  localparam int POS_W          = 6;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [7:0]  hi;
    logic [63:0] lo;
  } name_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] name_lo;
    logic [7:0]  name_hi;
  } req_t;

  typedef struct packed {
    status_e     status;
    pos_t        position;
    logic [63:0] entry_lo;
    logic [7:0]  entry_hi;
    logic        last;
  } rsp_t;

endpackage

### sv/ordered_name_table_unit.sv
// ----------------------------------------------------------------------------
// Ordered name table unit
// Keeps an ordered table of fixed-width names in one synchronous memory and
// serves create, delete, search and list commands one at a time.
// ----------------------------------------------------------------------------
// A command beat is taken on req while req_ready is high, which is only when
// no earlier command is still in work. Every command gives one or more beats
// on rsp; the final one has last set. List gives one beat per stored entry,
// or one STAT_EMPTY beat for an empty table. A create's result shows in
// the cycle after the command is taken. Search and delete scan the table
// through the single memory read port, with a read and a compare per entry
// visited; a delete then moves every later entry down, with a read and a
// write per entry moved. A list takes each entry through a read, a compare
// and an output beat. The registered read port puts each read in its own
// step. A stalled rsp beat simply holds, and the block waits.
// Reset empties the table at once by clearing the entry count; the memory
// itself is not swept, and entries at or beyond the count are never read.
// ----------------------------------------------------------------------------
module ordered_name_table_unit #(
  parameter int DEPTH      = ont_pkg::DEPTH_DEF,
  parameter int NAME_BYTES = ont_pkg::NAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ont_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ont_pkg::rsp_t rsp
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [63:0] LO_MASK = (NAME_BYTES >= 8) ? {64{1'b1}} :
                                    ((64'd1 << (8 * NAME_BYTES)) - 64'd1);
  localparam logic [7:0]  HI_MASK = (NAME_BYTES >= 9) ? 8'hff : 8'h00;

  ont_pkg::name_t  mem [DEPTH];

  ont_pkg::state_e state, state_next;
  ont_pkg::cmd_e   cmd, cmd_next;
  ont_pkg::name_t  key, key_next;
  ont_pkg::rsp_t   res, res_next;
  ont_pkg::name_t  rd_data;
  logic [AW-1:0]    idx, idx_next;
  logic [AW-1:0]    hit, hit_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx_inc;
  logic             last_idx;
  logic             match;
  logic             shift_done;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  ont_pkg::name_t  mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;

  assign idx_inc    = CNT_W'(idx) + CNT_W'(1);
  assign last_idx   = (idx_inc == count);
  assign shift_done = (idx_inc == count - CNT_W'(1));
  assign match      = (rd_data == key);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ont_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.cmd == ont_pkg::CMD_CREATE || count == '0) begin
            state_next = ont_pkg::ST_OUT;
          end else begin
            state_next = ont_pkg::ST_READ;
          end
        end
      end
      ont_pkg::ST_READ: state_next = ont_pkg::ST_CHECK;
      ont_pkg::ST_CHECK: begin
        case (cmd)
          ont_pkg::CMD_LIST: state_next = ont_pkg::ST_OUT;
          ont_pkg::CMD_SEARCH: begin
            state_next = (match || last_idx) ? ont_pkg::ST_OUT : ont_pkg::ST_READ;
          end
          ont_pkg::CMD_DELETE: begin
            if (match) begin
              state_next = last_idx ? ont_pkg::ST_OUT : ont_pkg::ST_SHIFT_RD;
            end else begin
              state_next = last_idx ? ont_pkg::ST_OUT : ont_pkg::ST_READ;
            end
          end
          default: state_next = ont_pkg::ST_OUT;
        endcase
      end
      ont_pkg::ST_SHIFT_RD: state_next = ont_pkg::ST_SHIFT_WR;
      ont_pkg::ST_SHIFT_WR: begin
        state_next = shift_done ? ont_pkg::ST_OUT : ont_pkg::ST_SHIFT_RD;
      end
      ont_pkg::ST_OUT: begin
        if (rsp_ready) begin
          if (cmd == ont_pkg::CMD_LIST && !res.last) begin
            state_next = ont_pkg::ST_READ;
          end else begin
            state_next = ont_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = ont_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_next   = cmd;
    key_next   = key;
    res_next   = res;
    idx_next   = idx;
    hit_next   = hit;
    count_next = count;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = rd_data;
    mem_re     = 1'b0;
    mem_raddr  = idx;
    case (state)
      ont_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd_next    = req.cmd;
          key_next.lo = req.name_lo & LO_MASK;
          key_next.hi = req.name_hi & HI_MASK;
          idx_next    = '0;
          res_next    = '0;
          res_next.last = 1'b1;
          if (req.cmd == ont_pkg::CMD_CREATE) begin
            if (count == CNT_W'(DEPTH)) begin
              res_next.status = ont_pkg::STAT_FULL;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = AW'(count);
              mem_wdata.lo = req.name_lo & LO_MASK;
              mem_wdata.hi = req.name_hi & HI_MASK;
              count_next   = count + CNT_W'(1);
            end
          end else if (count == '0) begin
            res_next.status = (req.cmd == ont_pkg::CMD_LIST) ?
                              ont_pkg::STAT_EMPTY : ont_pkg::STAT_NOT_FOUND;
          end
        end
      end
      ont_pkg::ST_READ: begin
        mem_re = 1'b1;
      end
      ont_pkg::ST_CHECK: begin
        res_next = '0;
        case (cmd)
          ont_pkg::CMD_LIST: begin
            res_next.position = ont_pkg::pos_t'(idx_inc);
            res_next.entry_lo = rd_data.lo;
            res_next.entry_hi = rd_data.hi;
            res_next.last     = last_idx;
          end
          ont_pkg::CMD_SEARCH, ont_pkg::CMD_DELETE: begin
            res_next.last = 1'b1;
            if (match) begin
              hit_next          = idx;
              res_next.position = ont_pkg::pos_t'(idx_inc);
              if (cmd == ont_pkg::CMD_DELETE && last_idx) begin
                count_next = count - CNT_W'(1);
              end
            end else if (last_idx) begin
              res_next.status = ont_pkg::STAT_NOT_FOUND;
            end else begin
              idx_next = idx + AW'(1);
            end
          end
          default: res_next.last = 1'b1;
        endcase
      end
      ont_pkg::ST_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(idx_inc);
      end
      ont_pkg::ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = rd_data;
        idx_next  = idx + AW'(1);
        if (shift_done) begin
          count_next = count - CNT_W'(1);
          res_next   = '0;
          res_next.position = ont_pkg::pos_t'(CNT_W'(hit) + CNT_W'(1));
          res_next.last     = 1'b1;
        end
      end
      ont_pkg::ST_OUT: begin
        if (rsp_ready && cmd == ont_pkg::CMD_LIST && !res.last) begin
          idx_next = idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    req_ready = (state == ont_pkg::ST_IDLE);
    rsp_valid = (state == ont_pkg::ST_OUT);
    rsp       = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ont_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    cmd <= cmd_next;
    key <= key_next;
    res <= res_next;
    idx <= idx_next;
    hit <= hit_next;
  end

endmodule

### sv/ont_checker.sv
// ----------------------------------------------------------------------------
// Ordered name table checker
// Port-level assertions for the ordered name table unit, bound to its top.
// ----------------------------------------------------------------------------
module ont_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ont_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ont_pkg::rsp_t rsp
);

  // A stalled result beat holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp beat changed while stalled");

  // The unit never takes a command while a result is still pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("req_ready high while a result is pending");

  // A result that is not ok carries no position or entry and ends the command.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ont_pkg::STAT_OK |->
      rsp.position == '0 && rsp.entry_lo == '0 && rsp.entry_hi == '0 && rsp.last)
    else $error("failed result carries data or is not last");

  // After a list beat that is not last, the unit stays busy with the list.
  a_list_continues: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp.last |=> !req_ready)
    else $error("new command accepted in the middle of a list");

  // Reset leaves no result pending.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

  logic unused_req;
  assign unused_req = req_valid ^ (^req);

endmodule

bind ordered_name_table_unit ont_checker u_ont_checker (.*);
